[src/nsga_pkg.sv]
// Shared constants and types for the slice gather address generator.
package nsga_pkg;

	localparam int IDX_W      = 32;   // flat index width, wraps as 32-bit
	localparam int OFF_W      = 35;   // byte offset width
	localparam int EB_W       = 4;    // element_bytes register width
	localparam int CNT_W      = 3;    // axis_count register width
	localparam int PACK_W     = 64;   // packed extent register width
	localparam int BEGIN_W    = 32;   // packed begin register width
	localparam int BEGIN_BITS = 8;    // one begin offset
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DIV_BITS   = 4;    // quotient bits resolved per stage
	localparam int DIV_STG    = IDX_W / DIV_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_SIZES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BEGINS     = 3'd4;

	typedef struct packed {
		logic [IDX_W-1:0] src;
		logic [OFF_W-1:0] off;
		logic             last;
		logic             err;
	} result_t;

endpackage

[src/nsga_div_step.sv]
// STEPS restoring-division steps: shifts dividend bits into the remainder.
module nsga_div_step #(
	parameter int EXT_W = 16,
	parameter int STEPS = 4
) (
	input  logic [nsga_pkg::IDX_W-1:0] q_in,
	input  logic [EXT_W-1:0]           r_in,
	input  logic [EXT_W-1:0]           divisor,
	output logic [nsga_pkg::IDX_W-1:0] q_out,
	output logic [EXT_W-1:0]           r_out
);

	always_comb begin
		logic [nsga_pkg::IDX_W-1:0] q;
		logic [EXT_W-1:0]           r;
		logic [EXT_W:0]             t;
		q = q_in;
		r = r_in;
		for (int s = 0; s < STEPS; s++) begin
			t = {r, q[nsga_pkg::IDX_W-1]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
				q = {q[nsga_pkg::IDX_W-2:0], 1'b1};
			end else begin
				q = {q[nsga_pkg::IDX_W-2:0], 1'b0};
			end
			r = t[EXT_W-1:0];
		end
		q_out = q;
		r_out = r;
	end

endmodule

[src/nd_slice_gather_address.sv]
// Top level: pipelined N-D slice gather address generator.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------
//  item     | item_valid / item_ready     | out_index[31:0], last_item
//  result   | result_valid / result_ready | source_index, source_byte_offset,
//           |                             | last_result, size_error
//  config   | cfg_valid / cfg_ready       | cfg_index[2:0], cfg_data[63:0]
//
// One request per cycle sustained while the output queue is not full. Each axis slot runs
// the per-axis divider (DIV_BITS quotient bits a stage), then a coordinate and a multiply stage.
// arst_n clears config to reset values and empties the pipe and output queue.
// A full two-entry output queue freezes the whole pipe; nothing is lost or repeated.
// cfg_ready is always high.
module nd_slice_gather_address #(
	parameter int MAX_AXES    = 4,
	parameter int EXTENT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [nsga_pkg::IDX_W-1:0]        out_index,
	input  logic                              last_item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [nsga_pkg::IDX_W-1:0]        source_index,
	output logic [nsga_pkg::OFF_W-1:0]        source_byte_offset,
	output logic                              last_result,
	output logic                              size_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nsga_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nsga_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IW   = nsga_pkg::IDX_W;
	localparam int EW   = EXTENT_BITS;
	localparam int SPS  = nsga_pkg::DIV_STG + 2;   // stages per axis slot
	localparam int NST  = MAX_AXES * SPS + 2;
	localparam int N_W  = $clog2(MAX_AXES + 1);

	// ---------------- configuration registers ----------------
	logic [nsga_pkg::CNT_W-1:0]   axis_count_q;
	logic [nsga_pkg::EB_W-1:0]    elem_bytes_q;
	logic [nsga_pkg::PACK_W-1:0]  out_sizes_q;
	logic [nsga_pkg::PACK_W-1:0]  src_sizes_q;
	logic [nsga_pkg::BEGIN_W-1:0] begins_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_count_q <= '0;
			elem_bytes_q <= nsga_pkg::EB_W'(1);
			out_sizes_q  <= '0;
			src_sizes_q  <= '0;
			begins_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nsga_pkg::CFG_AXIS_COUNT: axis_count_q <= cfg_data[nsga_pkg::CNT_W-1:0];
				nsga_pkg::CFG_ELEM_BYTES: elem_bytes_q <= cfg_data[nsga_pkg::EB_W-1:0];
				nsga_pkg::CFG_OUT_SIZES:  out_sizes_q  <= cfg_data;
				nsga_pkg::CFG_SRC_SIZES:  src_sizes_q  <= cfg_data;
				nsga_pkg::CFG_BEGINS:     begins_q     <= cfg_data[nsga_pkg::BEGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// axes in use, saturated
	logic [N_W-1:0] n_axes;
	assign n_axes = (32'(axis_count_q) > MAX_AXES) ? N_W'(MAX_AXES) : N_W'(axis_count_q);

	logic size_bad;
	assign size_bad = (n_axes != '0) &&
		!(elem_bytes_q == 4'd1 || elem_bytes_q == 4'd2 ||
		  elem_bytes_q == 4'd4 || elem_bytes_q == 4'd8);

	// per-axis fields; fields past the register read as zero
	logic [EW-1:0]                  od_ax [MAX_AXES];
	logic [EW-1:0]                  sd_ax [MAX_AXES];
	logic [nsga_pkg::BEGIN_BITS-1:0] bg_ax [MAX_AXES];

	for (genvar a = 0; a < MAX_AXES; a++) begin : g_field
		localparam int TOP  = (a + 1) * EW;
		localparam int BTOP = (a + 1) * nsga_pkg::BEGIN_BITS;
		if (TOP <= nsga_pkg::PACK_W) begin : g_ext
			assign od_ax[a] = out_sizes_q[nsga_pkg::PACK_W-TOP +: EW];
			assign sd_ax[a] = src_sizes_q[nsga_pkg::PACK_W-TOP +: EW];
		end else begin : g_noext
			assign od_ax[a] = '0;
			assign sd_ax[a] = '0;
		end
		if (BTOP <= nsga_pkg::BEGIN_W) begin : g_bg
			assign bg_ax[a] = begins_q[nsga_pkg::BEGIN_W-BTOP +: nsga_pkg::BEGIN_BITS];
		end else begin : g_nobg
			assign bg_ax[a] = '0;
		end
	end

	// slot k handles axis n-1-k (innermost first) when k < n
	logic                            slot_act [MAX_AXES];
	logic [EW-1:0]                   slot_od  [MAX_AXES];
	logic [EW-1:0]                   slot_sd  [MAX_AXES];
	logic [nsga_pkg::BEGIN_BITS-1:0] slot_bg  [MAX_AXES];

	for (genvar k = 0; k < MAX_AXES; k++) begin : g_slot
		always_comb begin
			slot_act[k] = (32'(n_axes) > k);
			slot_od[k]  = '0;
			slot_sd[k]  = '0;
			slot_bg[k]  = '0;
			for (int a = 0; a < MAX_AXES; a++) begin
				if (slot_act[k] && (32'(n_axes) - 1 - k == a)) begin
					slot_od[k] = od_ax[a];
					slot_sd[k] = sd_ax[a];
					slot_bg[k] = bg_ax[a];
				end
			end
		end
	end

	// ---------------- pipeline ----------------
	typedef struct packed {
		logic                      v;
		logic                      last;
		logic [IW-1:0]             idx;    // original index for the zero-axis case
		logic [IW-1:0]             q;      // running quotient / next dividend
		logic [EW-1:0]             r;
		logic [IW-1:0]             dvd;    // dividend of the current slot
		logic [IW-1:0]             cb;     // coordinate plus begin
		logic [IW-1:0]             stride;
		logic [IW-1:0]             term;
		logic [IW-1:0]             acc;
		logic [nsga_pkg::OFF_W-1:0] off;
		logic                      err;
	} stage_t;

	stage_t pipe_s [NST+1];
	stage_t nxt    [NST];
	logic   adv;

	always_comb begin
		pipe_s[0]        = '0;
		pipe_s[0].v      = item_valid & item_ready;
		pipe_s[0].last   = last_item;
		pipe_s[0].idx    = out_index;
		pipe_s[0].q      = out_index;
		pipe_s[0].stride = IW'(1);
	end

	for (genvar i = 0; i < NST; i++) begin : g_stg
		localparam int SLOT = i / SPS;
		localparam int POS  = i % SPS;

		if (SLOT < MAX_AXES && POS < nsga_pkg::DIV_STG) begin : g_div
			logic [IW-1:0] q_o;
			logic [EW-1:0] r_o;
			nsga_div_step #(.EXT_W(EW), .STEPS(nsga_pkg::DIV_BITS)) u_div (
				.q_in    (pipe_s[i].q),
				.r_in    ((POS == 0) ? '0 : pipe_s[i].r),
				.divisor (slot_od[SLOT]),
				.q_out   (q_o),
				.r_out   (r_o)
			);
			always_comb begin
				nxt[i]   = pipe_s[i];
				nxt[i].q = q_o;
				nxt[i].r = r_o;
				if (POS == 0)
					nxt[i].dvd = pipe_s[i].q;
			end
		end else if (SLOT < MAX_AXES && POS == nsga_pkg::DIV_STG) begin : g_coord
			always_comb begin
				logic [IW-1:0] c;
				c          = (slot_od[SLOT] == '0) ? pipe_s[i].dvd : IW'(pipe_s[i].r);
				nxt[i]     = pipe_s[i];
				nxt[i].acc = pipe_s[i].acc + pipe_s[i].term;
				if (slot_act[SLOT]) begin
					nxt[i].cb = c + IW'(slot_bg[SLOT]);
				end else begin
					nxt[i].cb = '0;
					nxt[i].q  = pipe_s[i].dvd;
				end
			end
		end else if (SLOT < MAX_AXES) begin : g_mul
			always_comb begin
				nxt[i]        = pipe_s[i];
				nxt[i].term   = pipe_s[i].cb * pipe_s[i].stride;
				nxt[i].stride = pipe_s[i].stride * IW'(slot_sd[SLOT]);
			end
		end else if (i == MAX_AXES * SPS) begin : g_sum
			always_comb begin
				nxt[i]     = pipe_s[i];
				nxt[i].acc = pipe_s[i].acc + pipe_s[i].term;
			end
		end else begin : g_fin
			always_comb begin
				logic [IW-1:0] src;
				if (n_axes == '0)
					src = pipe_s[i].idx;
				else if (size_bad)
					src = '0;
				else
					src = pipe_s[i].acc;
				nxt[i]     = pipe_s[i];
				nxt[i].acc = src;
				nxt[i].err = size_bad;
				nxt[i].off = nsga_pkg::OFF_W'(src) * nsga_pkg::OFF_W'(elem_bytes_q);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pipe_s[i+1] <= '0;
			else if (adv)
				pipe_s[i+1] <= nxt[i];
		end
	end

	// ---------------- output queue ----------------
	nsga_pkg::result_t q0_q, q1_q, push_d;
	logic [1:0]        cnt_q;
	logic              push, pop;

	assign adv        = (cnt_q != 2'd2);
	assign item_ready = adv;
	assign push       = adv & pipe_s[NST].v;
	assign pop        = result_valid & result_ready;

	always_comb begin
		push_d.src  = pipe_s[NST].acc;
		push_d.off  = pipe_s[NST].off;
		push_d.last = pipe_s[NST].last;
		push_d.err  = pipe_s[NST].err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			q0_q <= q1_q;
			if (push && cnt_q == 2'd1)
				q0_q <= push_d;
			if (push && cnt_q == 2'd2)
				q1_q <= push_d;
		end else if (push) begin
			if (cnt_q == 2'd0)
				q0_q <= push_d;
			else
				q1_q <= push_d;
		end
	end

	assign result_valid       = (cnt_q != 2'd0);
	assign source_index       = q0_q.src;
	assign source_byte_offset = q0_q.off;
	assign last_result        = q0_q.last;
	assign size_error         = q0_q.err;

endmodule

[bench/tb_top.sv]
// Testbench for the N-D slice gather address generator: directed table, then random requests.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAXES = 4;
	localparam int EXT_W = 16;
	// pipe depth MAX_AXES*(DIV_STG+2)+2 plus output queue, rounded up
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [nsga_pkg::IDX_W-1:0] out_index = '0;
	logic last_item = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [nsga_pkg::IDX_W-1:0] source_index;
	logic [nsga_pkg::OFF_W-1:0] source_byte_offset;
	logic last_result;
	logic size_error;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [nsga_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [nsga_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	nd_slice_gather_address #(.MAX_AXES(NAXES), .EXTENT_BITS(EXT_W)) uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// local copy of the configuration
	logic [nsga_pkg::CNT_W-1:0]   m_axes;
	logic [nsga_pkg::EB_W-1:0]    m_ebytes;
	logic [nsga_pkg::PACK_W-1:0]  m_osz;
	logic [nsga_pkg::PACK_W-1:0]  m_ssz;
	logic [nsga_pkg::BEGIN_W-1:0] m_beg;

	nsga_pkg::result_t gather_expected[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 10;
	int recv_idle_pct = 61;
	bit hold_off = 1'b0;
	bit hold_req = 1'b0;

	function automatic nsga_pkg::result_t predict_gather(logic [nsga_pkg::IDX_W-1:0] idx,
			logic lst);
		nsga_pkg::result_t r;
		int n;
		logic [31:0] stride[NAXES];
		logic [31:0] rem, od, b, c, s;
		n = (m_axes > NAXES) ? NAXES : m_axes;
		r.last = lst;
		r.err = 1'b0;
		if (n == 0) begin
			s = idx;
		end else begin
			rem = idx;
			stride[n-1] = 1;
			for (int a = n - 1; a > 0; a--)
				stride[a-1] = stride[a] *
					32'(m_ssz[nsga_pkg::PACK_W-1-a*EXT_W -: EXT_W]);
			s = 0;
			for (int a = n - 1; a >= 0; a--) begin
				od = 32'(m_osz[nsga_pkg::PACK_W-1-a*EXT_W -: EXT_W]);
				b  = 32'(m_beg[nsga_pkg::BEGIN_W-1-a*nsga_pkg::BEGIN_BITS -:
					nsga_pkg::BEGIN_BITS]);
				if (od == 0) begin
					c = rem;
					rem = '1;
				end else begin
					c = rem % od;
					rem = rem / od;
				end
				s += (c + b) * stride[a];
			end
			if (!(m_ebytes inside {4'd1, 4'd2, 4'd4, 4'd8})) begin
				r.err = 1'b1;
				s = 0;
			end
		end
		r.src = s;
		r.off = nsga_pkg::OFF_W'(64'(s) * 64'(m_ebytes));
		return r;
	endfunction

	// valid stays high across back-to-back writes; set_all drops it after the last one
	task automatic write_reg(logic [nsga_pkg::CFG_IDX_W-1:0] i,
			logic [nsga_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= i;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (i)
			nsga_pkg::CFG_AXIS_COUNT: m_axes = d[nsga_pkg::CNT_W-1:0];
			nsga_pkg::CFG_ELEM_BYTES: m_ebytes = d[nsga_pkg::EB_W-1:0];
			nsga_pkg::CFG_OUT_SIZES:  m_osz = d;
			nsga_pkg::CFG_SRC_SIZES:  m_ssz = d;
			nsga_pkg::CFG_BEGINS:     m_beg = d[nsga_pkg::BEGIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [2:0] ax, logic [3:0] eb, logic [63:0] o, logic [63:0] s,
			logic [31:0] bg);
		write_reg(nsga_pkg::CFG_AXIS_COUNT, 64'(ax));
		write_reg(nsga_pkg::CFG_ELEM_BYTES, 64'(eb));
		write_reg(nsga_pkg::CFG_OUT_SIZES, o);
		write_reg(nsga_pkg::CFG_SRC_SIZES, s);
		write_reg(nsga_pkg::CFG_BEGINS, 64'(bg));
		cfg_valid <= 1'b0;
	endtask

	// wait for the pipe to empty, then for any leftover work to settle
	task automatic drain();
		item_valid <= 1'b0;	// sender stops offering
		while (gather_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one request; expectation is pushed when the handshake completes
	task automatic send_request(logic [nsga_pkg::IDX_W-1:0] idx, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		out_index <= idx;
		last_item <= lst;
		do @(posedge clk); while (!item_ready);
		gather_expected.push_back(predict_gather(idx, lst));
	endtask

	// directed table: configuration, request, and a hand-read result where obvious
	typedef struct {
		bit do_cfg;
		logic [2:0] ax;
		logic [3:0] eb;
		logic [63:0] o, s;
		logic [31:0] bg;
		logic [31:0] idx;
		logic lst;
		bit known;
		nsga_pkg::result_t want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	task automatic add_row(bit dc, logic [2:0] ax, logic [3:0] eb, logic [63:0] o,
			logic [63:0] s, logic [31:0] bg, logic [31:0] idx, logic lst, bit k,
			nsga_pkg::result_t w);
		dir_row_t r;
		r = '{dc, ax, eb, o, s, bg, idx, lst, k, w};
		dir_rows.push_back(r);
	endtask

	function automatic logic [63:0] rand_sizes(int maxv);
		logic [63:0] v;
		for (int a = 0; a < 4; a++)
			v[63-a*16 -: 16] = 16'($urandom_range(maxv));
		return v;
	endfunction

	// result side: stall pattern, long hold-off, and checking
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (gather_expected.size() == 0) begin
					$error("result with nothing expected: src %h", source_index);
					errors++;
				end else begin
					nsga_pkg::result_t e;
					e = gather_expected.pop_front();
					if (source_index !== e.src) begin
						$error("source_index exp %h got %h", e.src, source_index);
						errors++;
					end
					if (source_byte_offset !== e.off) begin
						$error("source_byte_offset exp %h got %h", e.off,
							source_byte_offset);
						errors++;
					end
					if (last_result !== e.last) begin
						$error("last_result exp %b got %b", e.last, last_result);
						errors++;
					end
					if (size_error !== e.err) begin
						$error("size_error exp %b got %b", e.err, size_error);
						errors++;
					end
				end
			end
			result_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver hold-off counted in its own process
	initial begin
		wait (hold_req);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		nsga_pkg::result_t w;
		logic [2:0] ax;
		logic [3:0] eb;
		logic [31:0] idx;
		m_axes = 0; m_ebytes = 1; m_osz = 0; m_ssz = 0; m_beg = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: plain copy, one byte elements
		w = '{32'hFFFF_FFFF, 35'hFFFF_FFFF, 1'b1, 1'b0};
		add_row(0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, w);
		w = '{32'h0, 35'h0, 1'b0, 1'b0};
		add_row(0, 0, 1, 0, 0, 0, 32'h0, 0, 1, w);
		// zero axes, 8-byte: offset keeps 35 bits
		w = '{32'hFFFF_FFFF, 35'h7_FFFF_FFF8, 1'b0, 1'b0};
		add_row(1, 0, 8, '1, '1, '1, 32'hFFFF_FFFF, 0, 1, w);
		// zero axes, bad size: never flagged
		w = '{32'h1234_5678, 35'(64'h1234_5678 * 3), 1'b1, 1'b0};
		add_row(1, 0, 3, 0, 0, 0, 32'h1234_5678, 1, 1, w);
		// bad size with axes: error, zeroed fields
		w = '{32'h0, 35'h0, 1'b0, 1'b1};
		add_row(1, 2, 15, {4{16'd5}}, {4{16'd7}}, '1, 32'hDEAD_BEEF, 0, 1, w);
		w = '{32'h0, 35'h0, 1'b1, 1'b1};
		add_row(1, 4, 0, {4{16'd3}}, {4{16'd9}}, 32'h0102_0304, 32'd77, 1, 1, w);
		// axis count above limit (saturates), zero extents, full extents
		add_row(1, 7, 4, {4{16'd3}}, {4{16'd9}}, 32'h0102_0304, 32'd77, 0, 0, w);
		add_row(1, 3, 2, 0, '1, '1, 32'hFFFF_FFFF, 1, 0, w);
		add_row(1, 4, 8, '1, '1, '1, 32'hFFFF_FFFF, 0, 0, w);
		add_row(0, 4, 8, '1, '1, '1, 32'h0, 1, 0, w);
		add_row(1, 1, 1, 64'hFFFF_0000_0000_0000, 0, 32'hFF00_0000, 32'h8000_0001, 0, 0, w);
		add_row(1, 2, 4, 64'h0004_0000_0000_0000 | 64'h0000_0006_0000_0000,
			64'h0000_000A_0000_0000, 32'h0203_0000, 32'd23, 1, 0, w);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].do_cfg) begin
				drain();
				set_all(dir_rows[i].ax, dir_rows[i].eb, dir_rows[i].o, dir_rows[i].s,
					dir_rows[i].bg);
			end
			send_request(dir_rows[i].idx, dir_rows[i].lst);
			if (dir_rows[i].known)
				gather_expected[$] = dir_rows[i].want;
		end

		// random phases: three idle patterns, several settings each
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin send_idle_pct = 61; recv_idle_pct = 10; end
			if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
			drain();
			ax = 3'($urandom_range(7));
			eb = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
				: 4'(1 << $urandom_range(3));
			set_all(ax, eb, ($urandom_range(3) == 0) ? rand_sizes(65535) : rand_sizes(12),
				($urandom_range(3) == 0) ? {$urandom, $urandom} : rand_sizes(40),
				$urandom);
			if (ph == 2) hold_req = 1'b1;	// receiver holds off during this phase, filling the queue and stalling the sender
			for (int k = 0; k < 128; k++) begin
				idx = ($urandom_range(1) == 0) ? 32'($urandom_range(5000)) : $urandom;
				send_request(idx, (k == 127) || ($urandom_range(15) == 0));
			end
			if (ph == 5) drain();	// sender pauses until all results are in
		end

		drain();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
